>>> hdl/assert_macros.svh
// Assertion macros used by the allocator datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> hdl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator
package ffba_pkg;

	localparam int MEM_UNITS_DEF = 1024;
	localparam int RES_W         = 10;
	localparam int BASE_W        = 10;
	localparam int COUNT_W       = 11;
	localparam logic [RES_W-1:0] RES_RST = 10'd64;

	typedef enum logic {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic mark_go;
		logic mark;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_release;
		logic skip;
		logic found;
		logic exhausted;
		logic mark_last;
	} dp_sts_t;

endpackage

>>> hdl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator
// After reset the block runs a clearing pass over the occupancy memory,
// one unit a cycle, with busy high; the reserved_units register may be
// written during it. A release of n units clears them from start_unit up,
// stopping at the last unit of the memory; nothing is freed when n is zero.
// An allocation reads the occupancy memory one unit a cycle through its
// single read port from unit 0 up to the last unit of the first fitting run
// (or to the usable limit on failure), then writes the n granted units one a
// cycle. The result stands on granted and base_unit from the cycle in which
// done is high (a single cycle, it cannot be held off) until the next request
// is loaded; a new request may be started in that same cycle.
module first_fit_block_allocator #(
	parameter int MEM_UNITS = ffba_pkg::MEM_UNITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [ffba_pkg::BASE_W-1:0]  start_unit,
	input  logic [ffba_pkg::COUNT_W-1:0] unit_count,
	input  logic                         cfg_we,
	input  logic [ffba_pkg::RES_W-1:0]   cfg_data,
	output logic                         done,
	output logic                         granted,
	output logic [ffba_pkg::BASE_W-1:0]  base_unit
);
	import ffba_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffba_datapath #(
		.MEM_UNITS (MEM_UNITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.start_unit (start_unit),
		.unit_count (unit_count),
		.granted    (granted),
		.base_unit  (base_unit),
		.done       (done)
	);

endmodule

>>> hdl/ffba_ctrl.sv
// Controller state machine of the first-fit block allocator
module ffba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffba_pkg::dp_sts_t  sts,
	output ffba_pkg::ctl_cmd_t cmd,
	output logic               busy
);
	import ffba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.mark_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.skip) state_d = ST_DONE;
				else if (sts.is_release) state_d = ST_MARK;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.found) state_d = ST_MARK;
				else if (sts.exhausted) state_d = ST_DONE;
			end
			ST_MARK: begin
				if (sts.mark_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.mark = 1'b1;
			end
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DECIDE: begin
				cmd.mark_go = sts.is_release && !sts.skip;
			end
			ST_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.mark_go = sts.found;
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hdl/ffba_datapath.sv
// Datapath of the first-fit block allocator: occupancy memory, scan and mark
`include "assert_macros.svh"
module ffba_datapath #(
	parameter int MEM_UNITS = ffba_pkg::MEM_UNITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffba_pkg::ctl_cmd_t           cmd,
	output ffba_pkg::dp_sts_t            sts,
	input  logic                         cfg_we,
	input  logic [ffba_pkg::RES_W-1:0]   cfg_data,
	input  logic                         req_type,
	input  logic [ffba_pkg::BASE_W-1:0]  start_unit,
	input  logic [ffba_pkg::COUNT_W-1:0] unit_count,
	output logic                         granted,
	output logic [ffba_pkg::BASE_W-1:0]  base_unit,
	output logic                         done
);
	import ffba_pkg::*;

	localparam int UW = $clog2(MEM_UNITS);
	localparam int PW = UW + 1;
	localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;
	localparam int BW = CW + 1;

	logic mem [MEM_UNITS];

	logic [RES_W-1:0]   res_q;
	logic               done_q;
	logic [PW-1:0]      wptr_q;
	logic [CW-1:0]      wcnt_q;
	logic               wval_q;
	logic [PW-1:0]      iss_q;
	logic               vld_s1;
	logic               rd_data_s1;
	logic [UW-1:0]      chk_s1;

	logic               req_q;
	logic [BASE_W-1:0]  start_q;
	logic [COUNT_W-1:0] count_q;
	logic [PW-1:0]      limit_q;
	logic [COUNT_W-1:0] run_q;
	logic               granted_q;
	logic [BASE_W-1:0]  base_q;

	logic               issue;
	logic               found;
	logic [BW-1:0]      found_base;
	logic [PW-1:0]      limit_d;

	assign issue      = cmd.scan && (iss_q < limit_q);
	assign found      = vld_s1 && !rd_data_s1
	                    && ((COUNT_W+1)'(run_q) + (COUNT_W+1)'(1) == (COUNT_W+1)'(count_q));
	assign found_base = BW'(chk_s1) + BW'(1) - BW'(count_q);
	assign limit_d    = (CW'(res_q) < CW'(MEM_UNITS))
	                    ? PW'(CW'(MEM_UNITS) - CW'(res_q)) : '0;

	always_comb begin
		sts.is_release = (req_q == REQ_RELEASE);
		sts.skip       = (count_q == '0)
		                 || ((req_q == REQ_RELEASE) && (CW'(start_q) >= CW'(MEM_UNITS)));
		sts.found      = found;
		sts.exhausted  = !vld_s1 && (iss_q >= limit_q);
		sts.mark_last  = (wcnt_q == CW'(1)) || (wptr_q == PW'(MEM_UNITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= RES_RST;
			done_q <= 1'b0;
			wptr_q <= '0;
			wcnt_q <= CW'(MEM_UNITS);
			wval_q <= 1'b0;
			iss_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) res_q <= cfg_data;
			done_q <= cmd.emit;
			if (cmd.load) begin
				iss_q  <= '0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= issue && !found;
				if (issue) iss_q <= iss_q + PW'(1);
			end
			if (cmd.mark_go) begin
				wcnt_q <= CW'(count_q);
				if (req_q == REQ_RELEASE) begin
					wptr_q <= PW'(start_q);
					wval_q <= 1'b0;
				end else begin
					wptr_q <= PW'(found_base);
					wval_q <= 1'b1;
				end
			end else if (cmd.mark) begin
				wptr_q <= wptr_q + PW'(1);
				wcnt_q <= wcnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			start_q   <= start_unit;
			count_q   <= unit_count;
			limit_q   <= limit_d;
			run_q     <= '0;
			granted_q <= (req_type == REQ_RELEASE);
			base_q    <= (req_type == REQ_RELEASE) ? start_unit : '0;
		end else if (cmd.scan && vld_s1) begin
			if (rd_data_s1) run_q <= '0;
			else run_q <= run_q + COUNT_W'(1);
			if (found) begin
				granted_q <= 1'b1;
				base_q    <= found_base[BASE_W-1:0];
			end
		end
		chk_s1 <= iss_q[UW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mark) mem[wptr_q[UW-1:0]] <= wval_q;
		rd_data_s1 <= mem[iss_q[UW-1:0]];
	end

	assign granted   = granted_q;
	assign base_unit = base_q;
	assign done      = done_q;

	`ASSERT_IMP(a_mark_in_range, clk, arst_n, cmd.mark, wptr_q < PW'(MEM_UNITS))
	`ASSERT_IMP(a_found_below_limit, clk, arst_n, cmd.scan && found, PW'(chk_s1) < limit_q)
	`ASSERT_IMP(a_found_nonzero, clk, arst_n, cmd.scan && found, count_q != '0)
	`ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

>>> tb/ffba_tb_pkg.sv
// Scoreboard with a first-fit occupancy predictor for the allocator testbench
package ffba_tb_pkg;
	import ffba_pkg::*;

	typedef struct packed {
		logic              granted;
		logic [BASE_W-1:0] base;
	} grant_t;

	class alloc_scoreboard;
		logic [RES_W-1:0]   reserved;
		bit                 used[MEM_UNITS_DEF];
		grant_t             grants[$];
		logic [BASE_W-1:0]  live_base[$];
		logic [COUNT_W-1:0] live_len[$];
		int                 errors;

		function new();
			reserved = RES_RST;
			errors = 0;
			foreach (used[k])
				used[k] = 1'b0;
		endfunction

		function void mark_run(int first, int len, bit v);
			for (int k = first; k < first + len && k < MEM_UNITS_DEF; k++)
				used[k] = v;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void note(req_t rq, logic [BASE_W-1:0] su, logic [COUNT_W-1:0] cnt);
			grant_t g;
			int lim, run, u, first;
			bit found;
			g = '0;
			found = 1'b0;
			run = 0;
			first = 0;
			if (rq == REQ_RELEASE) begin
				mark_run(int'(su), int'(cnt), 1'b0);
				g.granted = 1'b1;
				g.base = su;
			end else if (cnt != '0) begin
				lim = (int'(reserved) < MEM_UNITS_DEF) ? MEM_UNITS_DEF - int'(reserved) : 0;
				for (u = 0; u < lim && !found; u++) begin
					if (used[u]) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(cnt)) begin
							found = 1'b1;
							first = u + 1 - run;
						end
					end
				end
				if (found) begin
					mark_run(first, run, 1'b1);
					g.granted = 1'b1;
					g.base = first[BASE_W-1:0];
					live_base.push_back(first[BASE_W-1:0]);
					live_len.push_back(cnt);
				end
			end
			grants.push_back(g);
		endfunction

		function bit take_live(output logic [BASE_W-1:0] b, output logic [COUNT_W-1:0] c);
			int i;
			b = '0;
			c = '0;
			if (live_base.size() == 0)
				return 1'b0;
			i = $urandom_range(0, live_base.size() - 1);
			b = live_base[i];
			c = live_len[i];
			live_base.delete(i);
			live_len.delete(i);
			return 1'b1;
		endfunction

		function void check(logic gr, logic [BASE_W-1:0] b);
			grant_t g;
			if (grants.size() == 0) begin
				flag($sformatf("unexpected word: granted=%0d base_unit=%0d", gr, b));
				return;
			end
			g = grants.pop_front();
			if (gr !== g.granted || b !== g.base)
				flag($sformatf("mismatch: granted exp %0d got %0d, base_unit exp %0d got %0d",
					g.granted, gr, g.base, b));
		endfunction
	endclass

endpackage

>>> tb/tb.sv
// Top-level testbench of the first-fit block allocator
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;
	import ffba_tb_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic [BASE_W-1:0]  start_unit;
	logic [COUNT_W-1:0] unit_count;
	logic               cfg_we;
	logic [RES_W-1:0]   cfg_data;
	logic               done;
	logic               granted;
	logic [BASE_W-1:0]  base_unit;

	alloc_scoreboard sb;

	first_fit_block_allocator #(.MEM_UNITS(MEM_UNITS_DEF)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.start_unit (start_unit),
		.unit_count (unit_count),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.done       (done),
		.granted    (granted),
		.base_unit  (base_unit)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check(granted, base_unit);
	end

	task automatic send(req_t rq, logic [BASE_W-1:0] su, logic [COUNT_W-1:0] cnt);
		start <= 1'b1;
		req_type <= rq;
		start_unit <= su;
		unit_count <= cnt;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note(rq, su, cnt);
	endtask

	task automatic idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reserved(logic [RES_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		sb.reserved = v;
		cfg_we <= 1'b0;
	endtask

	task automatic directed();
		send(REQ_ALLOC, 10'd0, 11'd0);
		send(REQ_ALLOC, 10'd1023, 11'd1);
		send(REQ_ALLOC, 10'd0, 11'd5);
		send(REQ_RELEASE, 10'd0, 11'd1);
		send(REQ_ALLOC, 10'd0, 11'd2);
		send(REQ_ALLOC, 10'd0, 11'd1);
		send(REQ_ALLOC, 10'd0, 11'd961);
		send(REQ_ALLOC, 10'd1023, 11'd2047);
		send(REQ_RELEASE, 10'd1023, 11'd0);
		send(REQ_RELEASE, 10'd1000, 11'd100);
		send(REQ_RELEASE, 10'd512, 11'd8);
		send(REQ_RELEASE, 10'd0, 11'd1024);
		send(REQ_ALLOC, 10'd0, 11'd960);
		send(REQ_ALLOC, 10'd0, 11'd1);
		send(REQ_RELEASE, 10'd0, 11'd2047);
		write_reserved(10'd0);
		send(REQ_ALLOC, 10'd0, 11'd1024);
		send(REQ_ALLOC, 10'd0, 11'd1);
		send(REQ_RELEASE, 10'd1023, 11'd1);
		send(REQ_ALLOC, 10'd0, 11'd1);
		send(REQ_RELEASE, 10'd0, 11'd1024);
		write_reserved(10'd1023);
		send(REQ_ALLOC, 10'd682, 11'd1);
		send(REQ_ALLOC, 10'd341, 11'd1);
		send(REQ_RELEASE, 10'd0, 11'd1);
	endtask

	task automatic random_phase(int n, bit gaps);
		int k, pick;
		logic [BASE_W-1:0] b;
		logic [COUNT_W-1:0] c;
		for (k = 0; k < n; k++) begin
			if (gaps && $urandom_range(0, 3) == 0)
				idle($urandom_range(1, 11));
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				c = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 2047))
					: COUNT_W'($urandom_range(0, 40));
				send(REQ_RELEASE, BASE_W'($urandom), c);
			end else if (pick < 18) begin
				c = ($urandom_range(0, 1) == 0) ? '0 : COUNT_W'($urandom_range(0, 2047));
				send(REQ_ALLOC, BASE_W'($urandom), c);
			end else if ((pick < 55 || sb.live_len.size() > 10) && sb.take_live(b, c)) begin
				send(REQ_RELEASE, b, c);
			end else begin
				c = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(25, 400))
					: COUNT_W'($urandom_range(1, 24));
				send(REQ_ALLOC, BASE_W'($urandom), c);
			end
		end
	endtask

	initial begin
		int p;
		int phase_res[8];
		phase_res = '{64, 0, 1023, -1, 900, -1, 1, 64};
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_ALLOC;
		start_unit <= '0;
		unit_count <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		directed();
		for (p = 0; p < 8; p++) begin
			write_reserved((phase_res[p] < 0) ? RES_W'($urandom_range(0, 1023))
				: RES_W'(phase_res[p]));
			random_phase(70, p < 7);
		end
		drain();
		repeat (2100) @(posedge clk);
		if (sb.errors == 0 && sb.grants.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_ctrl.sv
hdl/ffba_datapath.sv
hdl/first_fit_block_allocator.sv
tb/ffba_tb_pkg.sv
tb/tb.sv
